// ===== hdl/rmq_pkg.sv =====
// rmq_pkg: shared widths, payload types and helpers for the
// rotation matrix to quaternion pipeline
// no dependencies
package rmq_pkg;

  localparam int MAT_W     = 16;   // matrix element, signed q1.15
  localparam int OUT_W     = 17;   // quaternion component
  localparam int ARG_W     = 18;   // clamped root argument
  localparam int ARGS_W    = 19;   // signed root argument before clamping
  localparam int TR_W      = 18;   // trace
  localparam int ROOT_W    = 9;    // floor sqrt of an ARG_W value
  localparam int SQ_REM_W  = 10;   // root remainder, at most twice the root
  localparam int SQ_STEPS  = ARG_W / 2;
  localparam int S_W       = 16;   // root times the scale
  localparam int HALF_W    = 15;
  localparam int SCALE_W   = 8;
  localparam int QUO_W     = 19;   // 2^26 / s for s >= scale
  localparam int DIV_STEPS = 27;   // numerator bits of 2^26
  localparam int RECIP_W   = QUO_W + 3;
  localparam int PROD_W    = OUT_W + RECIP_W + 1;
  localparam int FRAC_W    = 15;
  localparam int SH_W      = PROD_W - FRAC_W;

  localparam logic [SCALE_W-1:0] ROOT_SCALE = 8'd181;
  localparam logic signed [ARGS_W-1:0] ONE_Q15 = 19'sd32768;
  localparam logic signed [SH_W-1:0] OUT_MAX = 25'sd65535;
  localparam logic signed [SH_W-1:0] OUT_MIN = -25'sd65536;
  localparam logic [1:0] AXIS_W_IDX = 2'd3;

  // operands waiting for the reciprocal, and which slot takes s / 2
  typedef struct packed {
    logic [3:0][OUT_W-1:0] comp;
    logic [1:0]            sel;
  } pay_t;

  typedef struct packed {
    pay_t                pay;
    logic [ARG_W-1:0]    arg;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_t;

  typedef struct packed {
    pay_t              pay;
    logic [S_W-1:0]    s;
    logic [HALF_W-1:0] half;
    logic [S_W-1:0]    rem;
    logic [QUO_W-1:0]  quo;
  } dv_t;

  // cyclic axis order 1, 2, 0
  function automatic logic [1:0] next_axis(input logic [1:0] a);
    logic [1:0] n;
    case (a)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/rmq_sqrt_cell.sv =====
// rmq_sqrt_cell: one digit of the restoring integer square root,
// two argument bits per cell, registered
// depends on rmq_pkg
module rmq_sqrt_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  rmq_pkg::sq_t data_i,
  output logic        valid_o,
  output rmq_pkg::sq_t data_o
);
  import rmq_pkg::*;

  logic [SQ_REM_W+1:0] rem_ext;
  logic [SQ_REM_W+1:0] trial;
  logic                ge;
  sq_t                 data_d;
  sq_t                 data_q;
  logic                valid_q;

  // bring down two bits and try root*4+1
  always_comb begin
    rem_ext = {data_i.rem, data_i.arg[ARG_W-1 -: 2]};
    trial   = {1'b0, data_i.root, 2'b01};
    ge      = rem_ext >= trial;
    data_d      = data_i;
    data_d.arg  = {data_i.arg[ARG_W-3:0], 2'b00};
    data_d.rem  = ge ? SQ_REM_W'(rem_ext - trial) : SQ_REM_W'(rem_ext);
    data_d.root = {data_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== hdl/rmq_div_cell.sv =====
// rmq_div_cell: one quotient bit of the restoring division 2^26 / s,
// registered
// depends on rmq_pkg
module rmq_div_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        num_bit_i,
  input  logic        valid_i,
  input  rmq_pkg::dv_t data_i,
  output logic        valid_o,
  output rmq_pkg::dv_t data_o
);
  import rmq_pkg::*;

  logic [S_W:0] rem_ext;
  logic         ge;
  dv_t          data_d;
  dv_t          data_q;
  logic         valid_q;

  // shift in the next numerator bit and subtract s when it fits
  always_comb begin
    rem_ext = {data_i.rem, num_bit_i};
    ge      = rem_ext >= {1'b0, data_i.s};
    data_d     = data_i;
    data_d.rem = ge ? S_W'(rem_ext - {1'b0, data_i.s}) : S_W'(rem_ext);
    data_d.quo = {data_i.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== hdl/rotation_matrix_to_quaternion_fixed_unit.sv =====
// rotation_matrix_to_quaternion_fixed_unit: 3x3 q1.15 rotation matrix to
// quaternion; front stage, square root cells, divider cells, product stage
// depends on rmq_pkg, rmq_sqrt_cell, rmq_div_cell
//
//  channel  dir  bits  content
//  s_axis   in   144   nine matrix elements, row major
//  m_axis   out  72    quat x, y, z, w (17 bits each)
//
// one request per cycle while not held; stages: front stage, 9 square root
// cells, scale stage, 27 divider cells, product stage, output register.
// the whole pipeline advances together; it holds when the output register
// is full and m_axis_tready_i is low. reset empties all stages.
module rotation_matrix_to_quaternion_fixed_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
  input  logic [143:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // quat_x, quat_y, quat_z, quat_w, 4 zero bits
  output logic [71:0]  m_axis_tdata_o
);
  import rmq_pkg::*;

  logic adv;

  logic signed [MAT_W-1:0] mat [3][3];
  logic signed [TR_W-1:0]  tr;
  logic                    pos;
  logic [1:0]              ax_i, ax_j, ax_k;
  logic signed [ARGS_W-1:0] arg_s;
  sq_t                     front_d;

  logic valid_f_q;
  sq_t  front_q;

  logic sq_valid [SQ_STEPS+1];
  sq_t  sq_data  [SQ_STEPS+1];

  logic [S_W+1:0] s_full;
  dv_t  scale_d;
  logic valid_s_q;
  dv_t  scale_q;

  logic dv_valid [DIV_STEPS+1];
  dv_t  dv_data  [DIV_STEPS+1];

  logic [RECIP_W-1:0] recip;
  logic valid_p_q;
  logic signed [3:0][PROD_W-1:0] prod_d, prod_q;
  logic [HALF_W-1:0] half_q;
  logic [1:0]        sel_q;

  logic signed [SH_W-1:0] sh;
  logic [3:0][OUT_W-1:0]  quat_d;
  logic                   valid_o_q;
  logic [3:0][OUT_W-1:0]  quat_q;

  assign adv             = m_axis_tready_i || !valid_o_q;
  assign s_axis_tready_o = adv;

  // front: trace, branch, axis choice, root argument and operand sums and differences
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mat[r][c] = s_axis_tdata_i[(r*3+c)*MAT_W +: MAT_W];
      end
    end
    tr  = TR_W'(mat[0][0]) + TR_W'(mat[1][1]) + TR_W'(mat[2][2]);
    pos = tr > 0;
    ax_i = 2'd0;
    if (mat[1][1] > mat[0][0]) ax_i = 2'd1;
    if (mat[2][2] > mat[ax_i][ax_i]) ax_i = 2'd2;
    ax_j = next_axis(ax_i);
    ax_k = next_axis(ax_j);
    front_d = '0;
    if (pos) begin
      arg_s = ARGS_W'(tr) + ONE_Q15;
      front_d.pay.sel     = AXIS_W_IDX;
      front_d.pay.comp[0] = OUT_W'(mat[1][2]) - OUT_W'(mat[2][1]);
      front_d.pay.comp[1] = OUT_W'(mat[2][0]) - OUT_W'(mat[0][2]);
      front_d.pay.comp[2] = OUT_W'(mat[0][1]) - OUT_W'(mat[1][0]);
    end else begin
      arg_s = ARGS_W'(mat[ax_i][ax_i])
            - (ARGS_W'(mat[ax_j][ax_j]) + ARGS_W'(mat[ax_k][ax_k])) + ONE_Q15;
      front_d.pay.sel = ax_i;
      front_d.pay.comp[AXIS_W_IDX] = OUT_W'(mat[ax_j][ax_k]) - OUT_W'(mat[ax_k][ax_j]);
      for (int c = 0; c < 3; c++) begin
        if (2'(c) == ax_j) begin
          front_d.pay.comp[c] = OUT_W'(mat[ax_i][ax_j]) + OUT_W'(mat[ax_j][ax_i]);
        end else if (2'(c) == ax_k) begin
          front_d.pay.comp[c] = OUT_W'(mat[ax_i][ax_k]) + OUT_W'(mat[ax_k][ax_i]);
        end
      end
    end
    front_d.arg = arg_s[ARGS_W-1] ? '0 : arg_s[ARG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_f_q <= 1'b0;
    end else if (adv) begin
      valid_f_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      front_q <= front_d;
    end
  end

  // square root chain
  assign sq_valid[0] = valid_f_q;
  assign sq_data[0]  = front_q;

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_valid[g]),
      .data_i  (sq_data[g]),
      .valid_o (sq_valid[g+1]),
      .data_o  (sq_data[g+1])
    );
  end

  // scale the root into s and seed the divider
  always_comb begin
    s_full = (S_W+2)'(sq_data[SQ_STEPS].root) * (S_W+2)'(ROOT_SCALE);
    scale_d      = '0;
    scale_d.pay  = sq_data[SQ_STEPS].pay;
    scale_d.s    = s_full[S_W-1:0];
    scale_d.half = s_full[S_W-1:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s_q <= 1'b0;
    end else if (adv) begin
      valid_s_q <= sq_valid[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      scale_q <= scale_d;
    end
  end

  // divider chain, numerator 2^26 fed msb first
  assign dv_valid[0] = valid_s_q;
  assign dv_data[0]  = scale_q;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    rmq_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (adv),
      .num_bit_i ((g == 0) ? 1'b1 : 1'b0),
      .valid_i   (dv_valid[g]),
      .data_i    (dv_data[g]),
      .valid_o   (dv_valid[g+1]),
      .data_o    (dv_data[g+1])
    );
  end

  // reciprocal times operands, zero when s is zero
  always_comb begin
    recip = (dv_data[DIV_STEPS].s == '0) ? '0 : {dv_data[DIV_STEPS].quo, 3'b000};
    for (int c = 0; c < 4; c++) begin
      prod_d[c] = PROD_W'($signed(dv_data[DIV_STEPS].pay.comp[c]))
                * PROD_W'($signed({1'b0, recip}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_p_q <= 1'b0;
    end else if (adv) begin
      valid_p_q <= dv_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
      half_q <= dv_data[DIV_STEPS].half;
      sel_q  <= dv_data[DIV_STEPS].pay.sel;
    end
  end

  // floor shift, saturate, place s / 2
  always_comb begin
    sh = '0;
    for (int c = 0; c < 4; c++) begin
      sh = prod_q[c][PROD_W-1:FRAC_W];
      if (2'(c) == sel_q) begin
        quat_d[c] = {2'b00, half_q};
      end else if (sh > OUT_MAX) begin
        quat_d[c] = OUT_MAX[OUT_W-1:0];
      end else if (sh < OUT_MIN) begin
        quat_d[c] = OUT_MIN[OUT_W-1:0];
      end else begin
        quat_d[c] = sh[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o_q <= 1'b0;
    end else if (adv) begin
      valid_o_q <= valid_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      quat_q <= quat_d;
    end
  end

  assign m_axis_tvalid_o = valid_o_q;
  assign m_axis_tdata_o  = {4'b0000, quat_q};

`ifndef SYNTHESIS
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid[SQ_STEPS] |-> sq_data[SQ_STEPS].root <= 9'd362)
    else $error("square root out of range");

  a_scale_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && sq_valid[SQ_STEPS] |=> valid_s_q)
    else $error("scale stage dropped a request");

  a_pos_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && adv && pos |=> front_q.pay.sel == AXIS_W_IDX)
    else $error("positive trace must place s / 2 in w");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> valid_o_q && $stable(quat_q))
    else $error("stalled result changed");
`endif
endmodule
